FILE: rtl/core/cglu_pkg.sv
`default_nettype none
package cglu_pkg;
  localparam int MaxLanes    = 16;
  localparam int LaneW       = $clog2(MaxLanes);
  localparam int LitW        = $clog2(MaxLanes + 1);
  localparam int RowW        = 16;
  localparam int ParW        = RowW + 1;
  localparam int ColorCount  = 8;
  localparam int ColorW      = 3;
  localparam int MaxParents  = 4;
  localparam int ParFields   = 4;
  localparam int SegBuf      = MaxLanes + ParFields + 4;
  localparam int SegIdxW     = $clog2(SegBuf);
  localparam int SegCntW     = $clog2(SegBuf + 1);
  localparam int MaxSegments = 32;

  localparam logic [1:0] YTop = 2'd0;
  localparam logic [1:0] YMid = 2'd1;
  localparam logic [1:0] YBot = 2'd2;

  typedef struct packed {
    logic [LaneW-1:0]  x1;
    logic [1:0]        y1;
    logic [LaneW-1:0]  x2;
    logic [1:0]        y2;
    logic [ColorW-1:0] color;
  } seg_t;
endpackage
`default_nettype wire

FILE: rtl/core/cglu_seg_buf.sv
`default_nettype none
module cglu_seg_buf (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [cglu_pkg::SegIdxW-1:0] waddr_i,
  input  cglu_pkg::seg_t               wdata_i,
  input  wire  [cglu_pkg::SegIdxW-1:0] raddr_i,
  input  wire                          oldest_first_i,
  output cglu_pkg::seg_t               rdata_o
);
  import cglu_pkg::*;

  seg_t buf_q [SegBuf];
  seg_t rd_q;
  seg_t rd;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      buf_q[waddr_i] <= wdata_i;
    end
    rd_q <= buf_q[raddr_i];
  end

  always_comb begin
    rd = rd_q;
    if (oldest_first_i) begin
      rd.y1 = YBot - rd_q.y1;
      rd.y2 = YBot - rd_q.y2;
    end
  end

  assign rdata_o = rd;
endmodule
`default_nettype wire

FILE: rtl/core/commit_graph_lane_layout_unit.sv
`default_nettype none
// Commit graph lane layout.
// Input channel (in_valid_i / in_stall_o): one commit row per transaction,
// children before parents, with row_index_i, parent_count_i and four parents.
// Output channel (out_valid_o / out_stall_i): one header transaction per row
// (is_header_o = 1) followed by segment_count_o segment transactions; last_o
// marks the final transaction of the row.
// Config channel (cfg_valid_i / cfg_ready_o): bit 0 of cfg_data_i sets
// oldest_first, which mirrors segment heights. Always ready.
// The lane table is swept one lane per cycle through a single shared
// compare unit: one sweep to find the dot, one for pass-through lanes, one for
// joins, and one per in-window parent, with the control states ALLOC, INC,
// FREE, PSEL, PDONE and FIN between them. The header follows the sweeps, and
// segments follow at one per cycle while the receiver does not stall. A new
// row is taken once the last result of the previous row is in the output
// register.
// A stall holds the output register and pauses emission.
// Reset clears the lane table, lane colours, colour counter and oldest_first.
module commit_graph_lane_layout_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [15:0] row_index_i,
  input  wire  [2:0]  parent_count_i,
  input  wire  signed [16:0] parent_a_i,
  input  wire  signed [16:0] parent_b_i,
  input  wire  signed [16:0] parent_c_i,
  input  wire  signed [16:0] parent_d_i,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        is_header_o,
  output logic [4:0]  lane_count_o,
  output logic [3:0]  dot_lane_o,
  output logic [2:0]  dot_color_o,
  output logic [2:0]  row_flags_o,
  output logic [5:0]  segment_count_o,
  output logic [3:0]  seg_x_start_o,
  output logic [1:0]  seg_y_start_o,
  output logic [3:0]  seg_x_end_o,
  output logic [1:0]  seg_y_end_o,
  output logic [2:0]  seg_color_o,
  output logic        last_o
);
  import cglu_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_ALLOC = 4'd2;
  localparam logic [3:0] S_PASS  = 4'd3;
  localparam logic [3:0] S_INC   = 4'd4;
  localparam logic [3:0] S_JOIN  = 4'd5;
  localparam logic [3:0] S_FREE  = 4'd6;
  localparam logic [3:0] S_PSEL  = 4'd7;
  localparam logic [3:0] S_PSCAN = 4'd8;
  localparam logic [3:0] S_PDONE = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [LaneW-1:0] LastLane = LaneW'(MaxLanes - 1);

  logic [3:0]          state_q, state_d;
  logic [RowW-1:0]     here_q;
  logic [2:0]          npar_q;
  logic [ParW-1:0]     par_q [ParFields];
  logic [2:0]          k_q;
  logic [LaneW-1:0]    i_q;
  logic                found_q;
  logic [LaneW-1:0]    m_q;
  logic [LaneW-1:0]    dot_q;
  logic [ColorW-1:0]   dotcol_q;
  logic [MaxLanes-1:0] join_q;
  logic [LitW-1:0]     wb_q;
  logic [2:0]          flags_q;
  logic [SegCntW-1:0]  nseg_q;
  logic [LaneW-1:0]    segmax_q;
  logic [LitW-1:0]     lc_q;
  logic [5:0]          j_q;
  logic [MaxLanes-1:0] valid_q;
  logic [RowW-1:0]     tgt_q [MaxLanes];
  logic [ColorW-1:0]   col_q [MaxLanes];
  logic [LitW-1:0]     lit_q;
  logic [ColorW-1:0]   nc_q;
  logic                oldest_q;

  logic [ParW-1:0]     cur_par;
  logic [RowW-1:0]     key;
  logic                hit;
  logic [LitW-1:0]     width_now;
  logic                has_free;
  logic [LaneW-1:0]    free_idx;
  logic [LaneW-1:0]    alloc_lane;
  logic                alloc_col;
  logic                alloc_grow;
  logic [ColorW-1:0]   nc_next;
  logic                seg_we;
  seg_t                seg_w;
  seg_t                seg_r;
  logic [5:0]          emit;
  logic [2:0]          npar_in;
  logic [LaneW-1:0]    seg_hi;
  logic [LitW-1:0]     lc_calc;
  logic                k_in;
  logic                accept;
  logic                load;
  logic [5:0]          rd_idx;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign cur_par     = par_q[k_q[1:0]];
  assign k_in        = k_q < npar_q;
  assign key         = (state_q == S_SCAN) ? here_q : cur_par[RowW-1:0];
  assign hit         = valid_q[i_q] && (tgt_q[i_q] == key);
  assign nc_next     = (nc_q == ColorW'(ColorCount - 1)) ? '0 : nc_q + 1'b1;
  assign emit        = ({1'b0, nseg_q} > 6'(MaxSegments)) ? 6'(MaxSegments)
                                                            : {1'b0, nseg_q};
  assign npar_in     = (parent_count_i > 3'(MaxParents)) ? 3'(MaxParents) : parent_count_i;
  assign load        = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);
  assign seg_hi      = (seg_w.x1 > seg_w.x2) ? seg_w.x1 : seg_w.x2;
  assign rd_idx      = (load || j_q == 6'd0) ? j_q : j_q - 6'd1;

  always_comb begin
    width_now = '0;
    has_free  = 1'b0;
    free_idx  = '0;
    for (int l = 0; l < MaxLanes; l++) begin
      if (valid_q[l]) begin
        width_now = LitW'(l + 1);
      end
      if (!has_free && !valid_q[l] && (LitW'(l) < lit_q)) begin
        has_free = 1'b1;
        free_idx = LaneW'(l);
      end
    end
  end

  always_comb begin
    alloc_col  = 1'b1;
    alloc_grow = 1'b0;
    if (has_free) begin
      alloc_lane = free_idx;
    end else if (lit_q >= LitW'(MaxLanes)) begin
      alloc_lane = LastLane;
      alloc_col  = 1'b0;
    end else begin
      alloc_lane = lit_q[LaneW-1:0];
      alloc_grow = 1'b1;
    end
  end

  always_comb begin
    lc_calc = width_now;
    if (wb_q > lc_calc) lc_calc = wb_q;
    if ({1'b0, dot_q} + 1'b1 > lc_calc) lc_calc = {1'b0, dot_q} + 1'b1;
    if ({1'b0, segmax_q} + 1'b1 > lc_calc) lc_calc = {1'b0, segmax_q} + 1'b1;
  end

  always_comb begin
    seg_we = 1'b0;
    seg_w  = '{x1: dot_q, y1: YMid, x2: dot_q, y2: YBot, color: dotcol_q};
    unique case (state_q)
      S_PASS: begin
        if ((LitW'(i_q) < wb_q) && valid_q[i_q] && (i_q != dot_q) && !join_q[i_q]) begin
          seg_we = 1'b1;
          seg_w  = '{x1: i_q, y1: YTop, x2: i_q, y2: YBot, color: col_q[i_q]};
        end
      end
      S_INC: begin
        if (valid_q[dot_q]) begin
          seg_we = 1'b1;
          seg_w  = '{x1: dot_q, y1: YTop, x2: dot_q, y2: YMid, color: dotcol_q};
        end
      end
      S_JOIN: begin
        if (join_q[i_q]) begin
          seg_we = 1'b1;
          seg_w  = '{x1: i_q, y1: YTop, x2: dot_q, y2: YMid, color: col_q[i_q]};
        end
      end
      S_PSEL: begin
        seg_we = k_in && cur_par[ParW-1] && (k_q == 3'd0);
      end
      S_PDONE: begin
        seg_we = 1'b1;
        if (k_q == 3'd0) begin
          if (found_q) begin
            seg_w = '{x1: dot_q, y1: YMid, x2: m_q, y2: YBot, color: col_q[m_q]};
          end
        end else if (found_q) begin
          seg_w = '{x1: dot_q, y1: YMid, x2: m_q, y2: YBot, color: col_q[m_q]};
        end else begin
          seg_w = '{x1: dot_q, y1: YMid, x2: alloc_lane, y2: YBot,
                    color: alloc_col ? nc_q : col_q[alloc_lane]};
        end
      end
      default: seg_we = 1'b0;
    endcase
  end

  cglu_seg_buf u_seg_buf (
    .clk_i          (clk_i),
    .we_i           (seg_we),
    .waddr_i        (nseg_q[SegIdxW-1:0]),
    .wdata_i        (seg_w),
    .raddr_i        (rd_idx[SegIdxW-1:0]),
    .oldest_first_i (oldest_q),
    .rdata_o        (seg_r)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (i_q == LastLane) state_d = S_ALLOC;
      S_ALLOC: state_d = S_PASS;
      S_PASS:  if (i_q == LastLane) state_d = S_INC;
      S_INC:   state_d = S_JOIN;
      S_JOIN:  if (i_q == LastLane) state_d = S_FREE;
      S_FREE:  state_d = S_PSEL;
      S_PSEL: begin
        if (!k_in) state_d = S_FIN;
        else if (!cur_par[ParW-1]) state_d = S_PSCAN;
      end
      S_PSCAN: if (i_q == LastLane) state_d = S_PDONE;
      S_PDONE: state_d = S_PSEL;
      S_FIN:   state_d = S_OUT;
      S_OUT:   if (load && (j_q == emit)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      lit_q    <= '0;
      nc_q     <= '0;
      oldest_q <= 1'b0;
      for (int l = 0; l < MaxLanes; l++) begin
        col_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        oldest_q <= cfg_data_i;
      end
      if ((state_q == S_ALLOC && !found_q) ||
          (state_q == S_PDONE && k_q != 3'd0 && !found_q)) begin
        if (alloc_col) begin
          col_q[alloc_lane] <= nc_q;
          nc_q              <= nc_next;
        end
        if (alloc_grow) begin
          lit_q <= lit_q + 1'b1;
        end
      end
      if (state_q == S_JOIN && join_q[i_q]) begin
        valid_q[i_q] <= 1'b0;
      end
      if (state_q == S_FREE) begin
        valid_q[dot_q] <= 1'b0;
      end
      if (state_q == S_PDONE) begin
        if (k_q == 3'd0) begin
          if (!found_q) begin
            valid_q[dot_q] <= 1'b1;
          end
        end else if (found_q) begin
          valid_q[m_q] <= 1'b1;
        end else begin
          valid_q[alloc_lane] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PDONE) begin
      if (k_q == 3'd0) begin
        if (!found_q) tgt_q[dot_q] <= cur_par[RowW-1:0];
      end else if (found_q) begin
        tgt_q[m_q] <= cur_par[RowW-1:0];
      end else begin
        tgt_q[alloc_lane] <= cur_par[RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      j_q         <= '0;
      nseg_q      <= '0;
    end else begin
      if (accept) begin
        nseg_q <= '0;
        j_q    <= '0;
      end else if (seg_we) begin
        nseg_q <= nseg_q + 1'b1;
      end
      if (load) begin
        out_valid_o <= 1'b1;
        j_q         <= j_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      here_q   <= row_index_i;
      npar_q   <= npar_in;
      par_q[0] <= parent_a_i;
      par_q[1] <= parent_b_i;
      par_q[2] <= parent_c_i;
      par_q[3] <= parent_d_i;
      i_q      <= '0;
      found_q  <= 1'b0;
      join_q   <= '0;
      segmax_q <= '0;
      flags_q  <= (npar_in > 3'd1 ? 3'b001 : 3'b000) | (npar_in == 3'd0 ? 3'b010 : 3'b000);
    end
    if (seg_we && (nseg_q == '0 || seg_hi > segmax_q)) begin
      segmax_q <= seg_hi;
    end
    unique case (state_q)
      S_SCAN: begin
        i_q <= i_q + 1'b1;
        if ((LitW'(i_q) < lit_q) && hit) begin
          if (!found_q) begin
            found_q <= 1'b1;
            dot_q   <= i_q;
          end else begin
            join_q[i_q] <= 1'b1;
          end
        end
      end
      S_ALLOC: begin
        wb_q <= width_now;
        if (!found_q) begin
          dot_q    <= alloc_lane;
          dotcol_q <= alloc_col ? nc_q : col_q[alloc_lane];
        end else begin
          dotcol_q <= col_q[dot_q];
        end
      end
      S_PASS, S_JOIN: i_q <= i_q + 1'b1;
      S_FREE: k_q <= '0;
      S_PSEL: begin
        if (k_in) begin
          i_q     <= '0;
          found_q <= 1'b0;
          if (cur_par[ParW-1]) begin
            flags_q[2] <= 1'b1;
            k_q        <= k_q + 1'b1;
          end
        end
      end
      S_PSCAN: begin
        i_q <= i_q + 1'b1;
        if (hit && !found_q && (k_q != 3'd0 || i_q < dot_q)) begin
          found_q <= 1'b1;
          m_q     <= i_q;
        end
      end
      S_PDONE: k_q <= k_q + 1'b1;
      S_FIN:   lc_q <= lc_calc;
      default: ;
    endcase
    if (load) begin
      if (j_q == '0) begin
        is_header_o     <= 1'b1;
        lane_count_o    <= lc_q;
        dot_lane_o      <= dot_q;
        dot_color_o     <= dotcol_q;
        row_flags_o     <= flags_q;
        segment_count_o <= emit;
        seg_x_start_o   <= '0;
        seg_y_start_o   <= '0;
        seg_x_end_o     <= '0;
        seg_y_end_o     <= '0;
        seg_color_o     <= '0;
      end else begin
        is_header_o     <= 1'b0;
        lane_count_o    <= '0;
        dot_lane_o      <= '0;
        dot_color_o     <= '0;
        row_flags_o     <= '0;
        segment_count_o <= '0;
        seg_x_start_o   <= seg_r.x1;
        seg_y_start_o   <= seg_r.y1;
        seg_x_end_o     <= seg_r.x2;
        seg_y_end_o     <= seg_r.y2;
        seg_color_o     <= seg_r.color;
      end
      last_o <= (j_q == emit);
    end
  end

  a_lit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q <= LitW'(MaxLanes))
    else $error("lane count beyond table size");

  a_valid_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_now <= lit_q)
    else $error("valid lane outside opened lanes");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o && !out_valid_o || in_stall_o)
    else $error("ready right after accept");

  a_header_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_header_o |-> lane_count_o > {1'b0, dot_lane_o})
    else $error("dot lane outside lane count");
endmodule
`default_nettype wire
